// ===== rtl/swdisp_pkg.sv =====
package swdisp_pkg;

    localparam int DEBOUNCE_SAMPLES_DEFAULT = 8;

    localparam logic [7:0] TICKS_PER_COUNT_RESET = 8'd5;
    localparam logic [3:0] BCD_NINE = 4'd9;
    localparam logic [6:0] HUNDREDTHS_LAST = 7'd99;
    localparam logic [13:0] SECONDS_LAST = 14'd9999;
    localparam logic [2:0] SCAN_LAST = 3'd5;

    localparam logic [2:0] DIGIT_HUND_ONES = 3'd0;
    localparam logic [2:0] DIGIT_HUND_TENS = 3'd1;
    localparam logic [2:0] DIGIT_SEC_ONES = 3'd2;
    localparam logic [2:0] DIGIT_SEC_TENS = 3'd3;
    localparam logic [2:0] DIGIT_SEC_HUNDREDS = 3'd4;
    localparam logic [2:0] DIGIT_SEC_THOUSANDS = 3'd5;

    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] SEG_DP_MASK = 8'h7F;

    typedef logic [3:0] bcd_t;

    typedef struct packed {
        logic reset_fell;
        logic start_fell;
    } key_events_t;

    typedef struct packed {
        bcd_t [1:0] hund_bcd;
        bcd_t [3:0] sec_bcd;
        logic [6:0] hundredths;
        logic [13:0] seconds;
        logic running;
    } watch_state_t;

    typedef struct packed {
        logic [2:0] digit_index;
        logic [7:0] segment_pattern;
        logic [6:0] centiseconds;
        logic [13:0] whole_seconds;
        logic running_flag;
    } result_t;

    // active-low segments, decimal point off
    function automatic logic [7:0] seg_code(bcd_t d);
        logic [7:0] code;
        case (d)
            4'd0: code = 8'hC0;
            4'd1: code = 8'hF9;
            4'd2: code = 8'hA4;
            4'd3: code = 8'hB0;
            4'd4: code = 8'h99;
            4'd5: code = 8'h92;
            4'd6: code = 8'h82;
            4'd7: code = 8'hF8;
            4'd8: code = 8'h80;
            4'd9: code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/swdisp_if.sv =====
interface swdisp_key_if;
    logic valid;
    logic ready;
    logic reset_key_level;
    logic start_key_level;

    modport source (output valid, output reset_key_level, output start_key_level, input ready);
    modport sink (input valid, input reset_key_level, input start_key_level, output ready);
endinterface

interface swdisp_result_if;
    logic valid;
    logic ready;
    logic [2:0] digit_index;
    logic [7:0] segment_pattern;
    logic [6:0] centiseconds;
    logic [13:0] whole_seconds;
    logic running_flag;

    modport source (
        output valid, output digit_index, output segment_pattern, output centiseconds,
        output whole_seconds, output running_flag, input ready
    );
    modport sink (
        input valid, input digit_index, input segment_pattern, input centiseconds,
        input whole_seconds, input running_flag, output ready
    );
endinterface

interface swdisp_cfg_if;
    logic valid;
    logic ready;
    logic [7:0] ticks_per_count;

    modport source (output valid, output ticks_per_count, input ready);
    modport sink (input valid, input ticks_per_count, output ready);
endinterface

// ===== rtl/swdisp_debounce.sv =====
module swdisp_debounce #(
    parameter int SAMPLES = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic level,
    output logic fell
);
    logic [SAMPLES-1:0] hist_reg;
    logic [SAMPLES-1:0] hist_next;
    logic stable_reg;
    logic stable_next;

    always_comb
    begin
        hist_next = {hist_reg[SAMPLES-2:0], level};
        if (hist_next == '0)
        begin
            stable_next = 1'b0;
        end
        else if (&hist_next)
        begin
            stable_next = 1'b1;
        end
        else
        begin
            stable_next = stable_reg;
        end
    end

    // the previous stable level is the registered one
    assign fell = stable_reg & ~stable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '1;
            stable_reg <= 1'b1;
        end
        else if (advance)
        begin
            hist_reg <= hist_next;
            stable_reg <= stable_next;
        end
    end
endmodule

// ===== rtl/swdisp_timer.sv =====
module swdisp_timer (
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  swdisp_pkg::key_events_t events,
    input  logic [7:0] ticks_per_count,
    output swdisp_pkg::watch_state_t state_next
);
    import swdisp_pkg::*;

    watch_state_t state_reg;
    logic [7:0] prescale_reg;
    logic [7:0] prescale_next;
    logic [7:0] prescale_inc;
    logic step;
    logic carry;
    watch_state_t base;

    always_comb
    begin
        carry = 1'b0;
        base = state_reg;
        if (events.reset_fell)
        begin
            base = '0;
        end
        if (events.start_fell)
        begin
            base.running = ~base.running;
        end

        // prescaler runs whether or not the watch counts
        prescale_inc = prescale_reg + 8'd1;
        if (prescale_inc >= ticks_per_count)
        begin
            prescale_next = '0;
            step = base.running;
        end
        else
        begin
            prescale_next = prescale_inc;
            step = 1'b0;
        end

        state_next = base;
        if (step)
        begin
            if (base.hundredths == HUNDREDTHS_LAST)
            begin
                state_next.hundredths = '0;
                state_next.hund_bcd = '0;
                if (base.seconds == SECONDS_LAST)
                begin
                    state_next.seconds = '0;
                end
                else
                begin
                    state_next.seconds = base.seconds + 14'd1;
                end
                // decimal carry chain over the seconds digits, nines wrap to zero
                carry = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    if (carry)
                    begin
                        state_next.sec_bcd[i] = (base.sec_bcd[i] == BCD_NINE) ? 4'd0
                                                : base.sec_bcd[i] + 4'd1;
                    end
                    carry = carry & (base.sec_bcd[i] == BCD_NINE);
                end
            end
            else
            begin
                state_next.hundredths = base.hundredths + 7'd1;
                if (base.hund_bcd[0] == BCD_NINE)
                begin
                    state_next.hund_bcd[0] = 4'd0;
                    state_next.hund_bcd[1] = base.hund_bcd[1] + 4'd1;
                end
                else
                begin
                    state_next.hund_bcd[0] = base.hund_bcd[0] + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            prescale_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            prescale_reg <= prescale_next;
        end
    end
endmodule

// ===== rtl/swdisp_display.sv =====
module swdisp_display (
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  swdisp_pkg::watch_state_t state,
    output logic [2:0] digit_index,
    output logic [7:0] segment_pattern
);
    import swdisp_pkg::*;

    logic [2:0] scan_reg;
    logic [2:0] scan_next;

    assign digit_index = scan_reg;
    assign scan_next = (scan_reg == SCAN_LAST) ? 3'd0 : scan_reg + 3'd1;

    // leading zeros blanked on the upper three seconds digits
    always_comb
    begin
        case (scan_reg)
            DIGIT_HUND_ONES: segment_pattern = seg_code(state.hund_bcd[0]);
            DIGIT_HUND_TENS: segment_pattern = seg_code(state.hund_bcd[1]);
            DIGIT_SEC_ONES: segment_pattern = seg_code(state.sec_bcd[0]) & SEG_DP_MASK;
            DIGIT_SEC_TENS:
                segment_pattern = (state.sec_bcd[3:1] != '0) ? seg_code(state.sec_bcd[1])
                                  : SEG_BLANK;
            DIGIT_SEC_HUNDREDS:
                segment_pattern = (state.sec_bcd[3:2] != '0) ? seg_code(state.sec_bcd[2])
                                  : SEG_BLANK;
            DIGIT_SEC_THOUSANDS:
                segment_pattern = (state.sec_bcd[3] != '0) ? seg_code(state.sec_bcd[3])
                                  : SEG_BLANK;
            default: segment_pattern = SEG_BLANK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (advance)
        begin
            scan_reg <= scan_next;
        end
    end
endmodule

// ===== rtl/swdisp_outbuf.sv =====
module swdisp_outbuf (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  swdisp_pkg::result_t push_data,
    output logic has_room,
    output logic pop_valid,
    input  logic pop_ready,
    output swdisp_pkg::result_t pop_data
);
    import swdisp_pkg::*;

    result_t entry_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic pop;

    assign has_room = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop = pop_valid & pop_ready;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end
endmodule

// ===== rtl/stopwatch_with_debounce_and_display_top.sv =====
// Stopwatch with two debounced keys and a six-digit multiplexed display. Each transfer on
// keys is one scan tick and yields exactly one transfer on result, in the next cycle at the
// earliest: the digit driven this tick with its active-low segments, plus the current time
// and running flag. A tick can be taken every cycle; the only limit is a two-entry result
// buffer, so keys.ready drops only while two results wait unread. Time is kept both in
// binary and as decimal digits, so the display needs no division. ticks_per_count may be
// written through cfg at any time the block is idle; cfg.ready is always high.
module stopwatch_with_debounce_and_display_top #(
    parameter int DEBOUNCE_SAMPLES = swdisp_pkg::DEBOUNCE_SAMPLES_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    swdisp_cfg_if.sink cfg,
    swdisp_key_if.sink keys,
    swdisp_result_if.source result
);
    import swdisp_pkg::*;

    logic [7:0] ticks_reg;
    logic accept;
    logic has_room;
    logic reset_key_fell;
    logic start_key_fell;
    key_events_t events;
    watch_state_t state_next;
    result_t res_in;
    result_t res_out;
    logic [2:0] digit_index;
    logic [7:0] segment_pattern;

    assign keys.ready = has_room;
    assign accept = keys.valid & has_room;
    assign cfg.ready = 1'b1;
    assign events = '{reset_fell: reset_key_fell, start_fell: start_key_fell};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_PER_COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            ticks_reg <= cfg.ticks_per_count;
        end
    end

    swdisp_debounce #(
        .SAMPLES(DEBOUNCE_SAMPLES)
    ) u_reset_key (
        .clk(clk),
        .rst_n(rst_n),
        .advance(accept),
        .level(keys.reset_key_level),
        .fell(reset_key_fell)
    );

    swdisp_debounce #(
        .SAMPLES(DEBOUNCE_SAMPLES)
    ) u_start_key (
        .clk(clk),
        .rst_n(rst_n),
        .advance(accept),
        .level(keys.start_key_level),
        .fell(start_key_fell)
    );

    swdisp_timer u_timer (
        .clk(clk),
        .rst_n(rst_n),
        .advance(accept),
        .events(events),
        .ticks_per_count(ticks_reg),
        .state_next(state_next)
    );

    swdisp_display u_display (
        .clk(clk),
        .rst_n(rst_n),
        .advance(accept),
        .state(state_next),
        .digit_index(digit_index),
        .segment_pattern(segment_pattern)
    );

    always_comb
    begin
        res_in.digit_index = digit_index;
        res_in.segment_pattern = segment_pattern;
        res_in.centiseconds = state_next.hundredths;
        res_in.whole_seconds = state_next.seconds;
        res_in.running_flag = state_next.running;
    end

    swdisp_outbuf u_outbuf (
        .clk(clk),
        .rst_n(rst_n),
        .push(accept),
        .push_data(res_in),
        .has_room(has_room),
        .pop_valid(result.valid),
        .pop_ready(result.ready),
        .pop_data(res_out)
    );

    assign result.digit_index = res_out.digit_index;
    assign result.segment_pattern = res_out.segment_pattern;
    assign result.centiseconds = res_out.centiseconds;
    assign result.whole_seconds = res_out.whole_seconds;
    assign result.running_flag = res_out.running_flag;
endmodule
